// File: sv/cnu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_pkg: shared types and constants of the catalan number unit
// widths of the datapath, the index range and the divider handshake structs
// ----------------------------------------------------------------------------
package cnu_pkg;

   // largest index whose result is computed, larger ones flag overflow
   localparam int MAX_INDEX = 31;
   // width of the accumulator and of the result value
   localparam int VALUE_W   = 64;
   // width of the index field
   localparam int INDEX_W   = 6;
   // width of a round multiplier and of a divisor
   localparam int FACTOR_W  = 6;
   // full product width before the overflow check
   localparam int PROD_W    = VALUE_W + FACTOR_W;
   // divider step counter width
   localparam int STEP_W    = $clog2(VALUE_W);

   localparam logic [INDEX_W-1:0] MAX_INDEX_CODE = INDEX_W'(MAX_INDEX);

   // request from the sequencer to the divider
   typedef struct packed {
      logic start;
   } div_ctl_type;

   // status from the divider to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage
`default_nettype wire

// File: sv/catalan_number_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// catalan_number_unit: nth catalan number as C(2n,n)/(n+1)
// sequencer with one multiply step and a shared iterative divider
// ----------------------------------------------------------------------------
// A request beat carries an index n; the response beat carries the catalan
// number of n, or 0 with overflow set when n is above 31 or a round
// product spills past 64 bits. The binomial C(2n,n) is built in n rounds:
// round i multiplies the accumulator by (2n - i) and divides the product
// exactly by (i + 1) in the shared bit-serial divider, one quotient bit per
// cycle over the 64 steps of the divider. A final division by (n + 1)
// yields the result. The unit takes one item at a time: req_stall stays
// high from the accepted beat until the response beat is taken.
// ----------------------------------------------------------------------------
module catalan_number_unit (
   input  wire                            clock,
   input  wire                            reset,
   // request channel
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [cnu_pkg::INDEX_W-1:0]     req_index,
   // response channel
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [cnu_pkg::VALUE_W-1:0]    rsp_value,
   output logic                           rsp_overflow
);

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,   // waiting for a request beat
      ST_MUL  = 6'b000010,   // round multiply, overflow check, divider start
      ST_DIV  = 6'b000100,   // round division running
      ST_LAST = 6'b001000,   // start the final division by n + 1
      ST_FDIV = 6'b010000,   // final division running
      ST_RESP = 6'b100000    // response beat held until taken
   } state_type;

   state_type                          state_ff, state_in;
   logic [cnu_pkg::INDEX_W-1:0]        n_ff, n_in;
   logic [cnu_pkg::INDEX_W-1:0]        round_ff, round_in;
   logic [cnu_pkg::VALUE_W-1:0]        acc_ff, acc_in;
   logic [cnu_pkg::VALUE_W-1:0]        value_ff, value_in;
   logic                               ovf_ff, ovf_in;

   // round arithmetic
   logic [cnu_pkg::INDEX_W:0]          twice_n;
   logic [cnu_pkg::INDEX_W:0]          factor_diff;
   logic [cnu_pkg::FACTOR_W-1:0]       mul_factor;
   logic [cnu_pkg::PROD_W-1:0]         product;
   logic [cnu_pkg::INDEX_W-1:0]        round_next;
   logic                               prod_wide;

   // divider hookup
   cnu_pkg::div_ctl_type               div_ctl;
   cnu_pkg::div_sts_type               div_sts;
   logic [cnu_pkg::VALUE_W-1:0]        div_dividend;
   logic [cnu_pkg::FACTOR_W-1:0]       div_divisor;
   logic [cnu_pkg::VALUE_W-1:0]        div_quotient;

   // multiplier for round i is 2n - i, never below n + 1
   assign twice_n     = {n_ff, 1'b0};
   assign factor_diff = twice_n - {1'b0, round_ff};
   assign mul_factor  = factor_diff[cnu_pkg::FACTOR_W-1:0];
   assign product     = cnu_pkg::PROD_W'(acc_ff) * cnu_pkg::PROD_W'(mul_factor);
   // product spills past the value width
   assign prod_wide   = (product[cnu_pkg::PROD_W-1:cnu_pkg::VALUE_W] != '0);
   assign round_next  = round_ff + 1'b1;

   // round divides the product by i + 1, the last step divides by n + 1
   assign div_dividend  = (state_ff == ST_MUL) ? product[cnu_pkg::VALUE_W-1:0] : acc_ff;
   assign div_divisor   = (state_ff == ST_MUL) ? round_next : n_ff + 1'b1;
   assign div_ctl.start = ((state_ff == ST_MUL) && !prod_wide) || (state_ff == ST_LAST);

   cnu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      round_in = round_ff;
      acc_in   = acc_ff;
      value_in = value_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = req_index;
               round_in = '0;
               acc_in   = cnu_pkg::VALUE_W'(1);
               ovf_in   = 1'b0;
               if (req_index > cnu_pkg::MAX_INDEX_CODE) begin
                  // index out of range: no rounds
                  acc_in   = '0;
                  value_in = '0;
                  ovf_in   = 1'b1;
                  state_in = ST_RESP;
               end else if (req_index == '0) begin
                  state_in = ST_LAST;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (prod_wide) begin
               // product does not fit, abandon the item
               acc_in   = '0;
               value_in = '0;
               ovf_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               acc_in   = div_quotient;
               round_in = round_next;
               state_in = (round_next == n_ff) ? ST_LAST : ST_MUL;
            end
         end
         ST_LAST: begin
            state_in = ST_FDIV;
         end
         ST_FDIV: begin
            if (div_sts.done) begin
               value_in = div_quotient;
               ovf_in   = 1'b0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         acc_ff   <= cnu_pkg::VALUE_W'(1);
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
      end
      n_ff     <= n_in;
      value_ff <= value_in;
   end

   // ports
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

`ifndef SYNTH
   // an overflowing beat always carries a zero value
   a_ovf_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_overflow || (rsp_value == '0)))
      else $error("overflow response with nonzero value");

   // an accepted request beat closes the request channel
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open after accept");

   // the divider is only started while idle
   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider restarted while busy");

   // a taken response beat is not repeated
   a_single_rsp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("response beat repeated");
`endif

endmodule
`default_nettype wire

// File: sv/cnu_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_divider: iterative restoring divider
// one quotient bit per cycle, wide dividend over a narrow nonzero divisor
// ----------------------------------------------------------------------------
module cnu_divider (
   input  wire                             clock,
   input  wire                             reset,
   input  cnu_pkg::div_ctl_type            ctl,
   input  wire [cnu_pkg::VALUE_W-1:0]      dividend,
   input  wire [cnu_pkg::FACTOR_W-1:0]     divisor,
   output cnu_pkg::div_sts_type            sts,
   output logic [cnu_pkg::VALUE_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cnu_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [cnu_pkg::VALUE_W-1:0]       quo_ff, quo_in;
   logic [cnu_pkg::FACTOR_W-1:0]      rem_ff, rem_in;
   logic [cnu_pkg::FACTOR_W-1:0]      dvs_ff, dvs_in;
   logic [cnu_pkg::FACTOR_W:0]        shifted;
   logic [cnu_pkg::FACTOR_W:0]        trial;

   // shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[cnu_pkg::VALUE_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = cnu_pkg::STEP_W'(cnu_pkg::VALUE_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[cnu_pkg::FACTOR_W]) begin
            rem_in = trial[cnu_pkg::FACTOR_W-1:0];
            quo_in = {quo_ff[cnu_pkg::VALUE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[cnu_pkg::FACTOR_W-1:0];
            quo_in = {quo_ff[cnu_pkg::VALUE_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
